>>> design/tcsb_pkg.sv
// ----------------------------------------------------------------------------
// Text console scroll buffer package
// Transaction types, field widths and key codes shared by the console blocks.
// ----------------------------------------------------------------------------
package tcsb_pkg;

  localparam int CELL_W      = 8;
  localparam int KEY_W       = 8;
  localparam int ADDR_FW     = 12;
  localparam int ROW_FW      = 5;
  localparam int COL_FW      = 7;
  localparam int PROMPT_W    = 7;

  localparam logic [KEY_W-1:0]    KEY_NONE      = 8'h00;
  localparam logic [KEY_W-1:0]    KEY_NEWLINE   = 8'h0a;
  localparam logic [KEY_W-1:0]    KEY_BACKSPACE = 8'h7f;

  localparam logic                REQ_KEY       = 1'b0;
  localparam logic                REQ_READ      = 1'b1;

  localparam logic [PROMPT_W-1:0] PROMPT_RESET  = 7'd2;

  typedef struct packed {
    logic               req_type;
    logic [KEY_W-1:0]   key_code;
    logic [ADDR_FW-1:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0]  read_data;
    logic [ROW_FW-1:0]  cursor_row;
    logic [COL_FW-1:0]  cursor_column;
    logic               scrolled;
  } out_item_t;

endpackage

>>> design/tcsb_screen_ram.sv
// ----------------------------------------------------------------------------
// Screen memory
// One write port and one registered read port over the character cells.
// ----------------------------------------------------------------------------
module tcsb_screen_ram
  import tcsb_pkg::*;
#(
  parameter int DEPTH = 2400,
  parameter int AW    = 12
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [CELL_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [CELL_W-1:0] rd_data
);

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/tcsb_ctrl.sv
// ----------------------------------------------------------------------------
// Console sequencer
// Cursor state, key handling, clear pass and the row copy that scrolls.
// ----------------------------------------------------------------------------
module tcsb_ctrl
  import tcsb_pkg::*;
#(
  parameter int COLUMNS    = 80,
  parameter int ROWS_COUNT = 30,
  parameter int AW         = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PROMPT_W-1:0] cfg_data,
  output logic                res_valid,
  input  logic                res_ready,
  output out_item_t           res_item,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output logic [CELL_W-1:0]   mem_wdata,
  output logic                mem_re,
  output logic [AW-1:0]       mem_raddr,
  input  logic [CELL_W-1:0]   mem_rdata
);

  localparam int CELLS = ROWS_COUNT * COLUMNS;
  localparam int RW    = $clog2(ROWS_COUNT);
  localparam int CW    = $clog2(COLUMNS + 1);

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_LAST = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0] BOT_BASE  = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] COL_STEP  = AW'(COLUMNS);
  localparam logic [AW-1:0] SRC_OFF   = AW'(COLUMNS + 1);
  localparam logic [AW-1:0] CNT_ONE   = AW'(1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS_COUNT - 1);
  localparam logic [RW-1:0] ROW_ONE   = RW'(1);
  localparam logic [CW-1:0] COL_MAX   = CW'(COLUMNS);
  localparam logic [CW-1:0] COL_ONE   = CW'(1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RDWAIT = 3'd2;
  localparam logic [2:0] ST_COPY   = 3'd3;
  localparam logic [2:0] ST_WIPE   = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]          state_r,    state_nxt;
  logic [AW-1:0]       cnt_r,      cnt_nxt;
  logic [RW-1:0]       row_r,      row_nxt;
  logic [AW-1:0]       base_r,     base_nxt;
  logic [CW-1:0]       col_r,      col_nxt;
  logic [PROMPT_W-1:0] prompt_r,   prompt_nxt;
  logic [CELL_W-1:0]   rdata_r,    rdata_nxt;
  logic                scrolled_r, scrolled_nxt;

  assign cfg_ready  = 1'b1;
  assign prompt_nxt = cfg_valid ? cfg_data : prompt_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    row_nxt      = row_r;
    base_nxt     = base_r;
    col_nxt      = col_r;
    rdata_nxt    = rdata_r;
    scrolled_nxt = scrolled_r;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = cnt_r;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = cnt_r + SRC_OFF;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNT_ONE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rdata_nxt    = '0;
          scrolled_nxt = 1'b0;
          state_nxt    = ST_DONE;
          if (in_data.req_type == REQ_READ) begin
            // out-of-range addresses read as zero
            if (32'(in_data.read_address) < CELLS) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(in_data.read_address);
              state_nxt = ST_RDWAIT;
            end
          end else if (in_data.key_code == KEY_NEWLINE) begin
            col_nxt = '0;
            if (row_r == LAST_ROW) begin
              // prefetch the first source cell of the scroll copy
              scrolled_nxt = 1'b1;
              cnt_nxt      = '0;
              mem_re       = 1'b1;
              mem_raddr    = COL_STEP;
              state_nxt    = ST_COPY;
            end else begin
              row_nxt  = row_r + ROW_ONE;
              base_nxt = base_r + COL_STEP;
            end
          end else if (in_data.key_code == KEY_BACKSPACE) begin
            if (32'(col_r) > 32'(prompt_r)) begin
              col_nxt   = col_r - COL_ONE;
              mem_we    = 1'b1;
              mem_waddr = base_r + AW'(col_r - COL_ONE);
            end
          end else if (in_data.key_code != KEY_NONE && col_r < COL_MAX) begin
            col_nxt   = col_r + COL_ONE;
            mem_we    = 1'b1;
            mem_waddr = base_r + AW'(col_r);
            mem_wdata = in_data.key_code;
          end
        end
      end

      ST_RDWAIT: begin
        rdata_nxt = mem_rdata;
        state_nxt = ST_DONE;
      end

      ST_COPY: begin
        // write the cell one row down into place, fetch the next one
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        if (cnt_r == COPY_LAST) begin
          cnt_nxt   = BOT_BASE;
          state_nxt = ST_WIPE;
        end else begin
          mem_re  = 1'b1;
          cnt_nxt = cnt_r + CNT_ONE;
        end
      end

      ST_WIPE: begin
        mem_we = 1'b1;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + CNT_ONE;
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      cnt_r    <= '0;
      row_r    <= ROW_ONE;
      base_r   <= COL_STEP;
      col_r    <= '0;
      prompt_r <= PROMPT_RESET;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      row_r    <= row_nxt;
      base_r   <= base_nxt;
      col_r    <= col_nxt;
      prompt_r <= prompt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r    <= rdata_nxt;
    scrolled_r <= scrolled_nxt;
  end

  assign res_item.read_data     = rdata_r;
  assign res_item.cursor_row    = ROW_FW'(row_r);
  assign res_item.cursor_column = COL_FW'(col_r);
  assign res_item.scrolled      = scrolled_r;

endmodule

>>> design/text_console_scroll_buffer_unit.sv
// ----------------------------------------------------------------------------
// Text console scroll buffer
// Character screen with cursor, backspace, newline and scroll-up.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per key byte (req_type 0) or cell read (req_type 1).
//   out_* : exactly one result transaction per input transaction, in order;
//           carries the read byte (zero for keys), the cursor after the item
//           and a flag set when the item scrolled the screen.
//   cfg_* : writes prompt_width; always ready, write only while idle.
// Sequencing:
//   A plain key item or off-screen read passes through the done state into
//   the output register; an on-screen read first waits for the registered
//   memory read. A new input is taken only once the previous result has
//   left the done state. A newline on the last row scrolls: the copy moves one
//   cell per cycle through the single screen memory, then the bottom row is
//   wiped.
// Reset:
//   rst_n clears the cursor to row 1, column 0 and prompt_width to 2, then a
//   clearing pass zeroes the screen, one cell per cycle, with in_ready low.
//   Configuration writes are taken throughout.
// Stall:
//   An output register holds the result while out_ready is low; the next
//   item is accepted meanwhile and its result waits until the slot frees.
// ----------------------------------------------------------------------------
module text_console_scroll_buffer_unit
  import tcsb_pkg::*;
#(
  parameter int COLUMNS    = 80,
  parameter int ROWS_COUNT = 30
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PROMPT_W-1:0] cfg_data
);

  localparam int CELLS = ROWS_COUNT * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  logic              res_valid;
  logic              res_ready;
  out_item_t         res_item;

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r;

  tcsb_ctrl #(
    .COLUMNS    (COLUMNS),
    .ROWS_COUNT (ROWS_COUNT),
    .AW         (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tcsb_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_screen (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // Output slot: free when empty or being drained this cycle.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    priority if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the payload only when a new result enters the slot.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> design/tcsb_checker.sv
// ----------------------------------------------------------------------------
// Console port checker
// Concurrent checks on the top-level ports, attached by bind.
// ----------------------------------------------------------------------------
module tcsb_checker
  import tcsb_pkg::*;
#(
  parameter int COLUMNS    = 80,
  parameter int ROWS_COUNT = 30
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  localparam logic [ROW_FW-1:0] LAST_ROW_F = ROW_FW'(ROWS_COUNT - 1);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // the column never runs past the line length
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.cursor_column) <= COLUMNS)
    else $error("cursor column beyond line length");

  // a scroll leaves the cursor at the start of the bottom row
  a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.scrolled |->
      out_data.cursor_row == LAST_ROW_F && out_data.cursor_column == '0)
    else $error("scroll left cursor off the bottom row start");

  // no item taken as the clearing pass starts after reset
  a_clear_pass: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ready)
    else $error("input accepted during clearing pass");

endmodule

bind text_console_scroll_buffer_unit tcsb_checker #(
  .COLUMNS    (COLUMNS),
  .ROWS_COUNT (ROWS_COUNT)
) u_checker (.*);
